// File: src/cfsv_pkg.sv
package cfsv_pkg;

   localparam int unsigned HDR_LEN     = 64;
   localparam int unsigned COUNT_W     = 23;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ONES    = 32'hFFFF_FFFF;
   localparam logic [7:0]  MAGIC_0     = 8'h46;
   localparam logic [7:0]  MAGIC_1     = 8'h43;
   localparam logic [7:0]  MAGIC_2     = 8'h57;
   localparam logic [7:0]  MAGIC_3     = 8'h31;
   localparam logic [15:0] HDR_VERSION = 16'd1;
   localparam logic [15:0] HDR_SIZE    = 16'd64;
   localparam int unsigned MAX_POINTS_DEFAULT = 1000000;

   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 64;
   localparam logic [CSR_IDX_W-1:0] CSR_ALGORITHM   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_MTIME = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PATH_FP     = 2'd3;

   typedef enum logic [3:0] {
      ST_OK          = 4'd0,
      ST_SHORT       = 4'd1,
      ST_MAGIC       = 4'd2,
      ST_VERSION     = 4'd3,
      ST_HDR_SIZE    = 4'd4,
      ST_HDR_CRC     = 4'd5,
      ST_COUNT       = 4'd6,
      ST_LENGTH      = 4'd7,
      ST_IDENTITY    = 4'd8,
      ST_PAYLOAD_CRC = 4'd9
   } status_type;

   typedef struct packed {
      logic [31:0] algorithm;
      logic [63:0] source_size;
      logic [63:0] source_mtime;
      logic [63:0] path_fp;
   } cfg_type;

   typedef struct packed {
      logic               short_file;
      logic               magic_ok;
      logic               version_ok;
      logic               hsize_ok;
      logic               hdr_crc_ok;
      logic               id_ok;
      logic               payload_crc_ok;
      logic [COUNT_W-1:0] total;
      logic [31:0]        band_points;
      logic [31:0]        smp_rate;
      logic [15:0]        xover_lo;
      logic [15:0]        xover_hi;
      logic [63:0]        frame_total;
   } job_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_stat_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return c;
   endfunction

endpackage

// File: src/cfsv_if.sv
interface cfsv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] file_byte;
   logic       is_last;

   modport source (output valid, output file_byte, output is_last, input ready);
   modport sink (input valid, input file_byte, input is_last, output ready);
endinterface

interface cfsv_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic [31:0] band_points;
   logic [31:0] smp_rate;
   logic [15:0] xover_lo;
   logic [15:0] xover_hi;
   logic [63:0] frame_total;

   modport source (output valid, output status, output band_points, output smp_rate,
                   output xover_lo, output xover_hi,
                   output frame_total, input ready);
   modport sink (input valid, input status, input band_points, input smp_rate,
                 input xover_lo, input xover_hi,
                 input frame_total, output ready);
endinterface

// File: src/cfsv_front.sv
module cfsv_front (
   input  logic                    clock,
   input  logic                    reset,
   cfsv_req_if.sink                req,
   input  cfsv_pkg::cfg_type       cfg,
   input  cfsv_pkg::queue_stat_type q_stat,
   output logic                    push,
   output cfsv_pkg::job_type       job
);

   logic [cfsv_pkg::COUNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]                  crc_ff, crc_in;
   logic                         good_ff, good_in;
   logic [7:0]                   hdr_ff [cfsv_pkg::HDR_LEN];

   logic                         accept;
   logic                         in_hdr;
   logic                         hdr_end;
   logic [7:0]                   crc_data;
   logic [31:0]                  crc_step;
   logic                         hdr_crc_match;
   logic [cfsv_pkg::COUNT_W-1:0] cnt_next;
   logic [31:0]                  payload_crc;

   assign req.ready = !q_stat.full;
   assign accept    = req.valid && req.ready;
   assign push      = accept && req.is_last;

   assign in_hdr   = (cnt_ff[cfsv_pkg::COUNT_W-1:6] == '0);
   assign hdr_end  = in_hdr && (cnt_ff[5:0] == 6'd63);
   assign crc_data = (in_hdr && (cnt_ff[5:2] == 4'hF)) ? 8'd0 : req.file_byte;
   assign crc_step = cfsv_pkg::crc_byte(crc_ff, crc_data);
   assign hdr_crc_match = ((crc_step ^ cfsv_pkg::CRC_ONES) ==
                           {req.file_byte, hdr_ff[62], hdr_ff[61], hdr_ff[60]});
   assign cnt_next = (cnt_ff != cfsv_pkg::COUNT_MAX) ?
                     cnt_ff + {{(cfsv_pkg::COUNT_W-1){1'b0}}, 1'b1} : cnt_ff;
   assign payload_crc = hdr_end ? 32'd0 : (crc_step ^ cfsv_pkg::CRC_ONES);

   always_comb begin
      cnt_in  = cnt_ff;
      crc_in  = crc_ff;
      good_in = good_ff;
      if (accept) begin
         if (req.is_last) begin
            cnt_in  = '0;
            crc_in  = cfsv_pkg::CRC_ONES;
            good_in = 1'b0;
         end else begin
            cnt_in = cnt_next;
            crc_in = hdr_end ? cfsv_pkg::CRC_ONES : crc_step;
            if (hdr_end) begin
               good_in = hdr_crc_match;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         crc_ff  <= cfsv_pkg::CRC_ONES;
         good_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         crc_ff  <= crc_in;
         good_ff <= good_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && in_hdr) begin
         hdr_ff[cnt_ff[5:0]] <= req.file_byte;
      end
   end

   always_comb begin
      job.short_file     = (cnt_next[cfsv_pkg::COUNT_W-1:6] == '0);
      job.magic_ok       = (hdr_ff[0] == cfsv_pkg::MAGIC_0) && (hdr_ff[1] == cfsv_pkg::MAGIC_1) &&
                           (hdr_ff[2] == cfsv_pkg::MAGIC_2) && (hdr_ff[3] == cfsv_pkg::MAGIC_3);
      job.version_ok     = ({hdr_ff[5], hdr_ff[4]} == cfsv_pkg::HDR_VERSION);
      job.hsize_ok       = ({hdr_ff[7], hdr_ff[6]} == cfsv_pkg::HDR_SIZE);
      job.hdr_crc_ok     = hdr_end ? hdr_crc_match : good_ff;
      job.id_ok          =
         ({hdr_ff[23], hdr_ff[22], hdr_ff[21], hdr_ff[20]} == cfg.algorithm) &&
         ({hdr_ff[31], hdr_ff[30], hdr_ff[29], hdr_ff[28],
           hdr_ff[27], hdr_ff[26], hdr_ff[25], hdr_ff[24]} == cfg.source_size) &&
         ({hdr_ff[39], hdr_ff[38], hdr_ff[37], hdr_ff[36],
           hdr_ff[35], hdr_ff[34], hdr_ff[33], hdr_ff[32]} == cfg.source_mtime) &&
         ({hdr_ff[55], hdr_ff[54], hdr_ff[53], hdr_ff[52],
           hdr_ff[51], hdr_ff[50], hdr_ff[49], hdr_ff[48]} == cfg.path_fp);
      job.payload_crc_ok = (payload_crc == {hdr_ff[59], hdr_ff[58], hdr_ff[57], hdr_ff[56]});
      job.total          = cnt_next;
      job.band_points    = {hdr_ff[11], hdr_ff[10], hdr_ff[9], hdr_ff[8]};
      job.smp_rate       = {hdr_ff[15], hdr_ff[14], hdr_ff[13], hdr_ff[12]};
      job.xover_lo       = {hdr_ff[17], hdr_ff[16]};
      job.xover_hi       = {hdr_ff[19], hdr_ff[18]};
      job.frame_total    = {hdr_ff[47], hdr_ff[46], hdr_ff[45], hdr_ff[44],
                            hdr_ff[43], hdr_ff[42], hdr_ff[41], hdr_ff[40]};
   end

`ifndef SYNTHESIS
   a_restart: assert property (@(posedge clock) disable iff (reset)
      push |=> (cnt_ff == '0) && (crc_ff == cfsv_pkg::CRC_ONES) && !good_ff)
      else $error("stream state not restarted after last byte");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !push)
      else $error("job pushed into full queue");
`endif

endmodule

// File: src/cfsv_queue.sv
module cfsv_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  cfsv_pkg::job_type        push_job,
   input  logic                     pop,
   output cfsv_pkg::job_type        head_job,
   output cfsv_pkg::queue_stat_type stat
);

   cfsv_pkg::job_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign stat     = '{full: (count_ff == 2'd2), not_empty: (count_ff != 2'd0)};
   assign head_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef SYNTHESIS
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("queue occupancy out of range");
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> stat.not_empty)
      else $error("pop from empty queue");
`endif

endmodule

// File: src/cfsv_back.sv
module cfsv_back #(
   parameter int unsigned MAX_POINTS = cfsv_pkg::MAX_POINTS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cfsv_pkg::queue_stat_type q_stat,
   input  cfsv_pkg::job_type        head_job,
   output logic                     pop,
   cfsv_rsp_if.source               rsp
);

   logic                 valid_ff, valid_in;
   cfsv_pkg::status_type status_ff, status_in;
   logic [31:0]          count_ff, count_in;
   logic [31:0]          rate_ff, rate_in;
   logic [15:0]          xlow_ff, xlow_in;
   logic [15:0]          xhigh_ff, xhigh_in;
   logic [63:0]          frames_ff, frames_in;

   logic [34:0]          exp_len;
   logic                 count_bad;

   assign pop = q_stat.not_empty && (!valid_ff || rsp.ready);

   assign exp_len   = 35'd64 + {3'd0, head_job.band_points} +
                      {2'd0, head_job.band_points, 1'b0};
   assign count_bad = (head_job.band_points == 32'd0) ||
                      (head_job.band_points > 32'(MAX_POINTS));

   always_comb begin
      if (head_job.short_file)                          status_in = cfsv_pkg::ST_SHORT;
      else if (!head_job.magic_ok)                      status_in = cfsv_pkg::ST_MAGIC;
      else if (!head_job.version_ok)                    status_in = cfsv_pkg::ST_VERSION;
      else if (!head_job.hsize_ok)                      status_in = cfsv_pkg::ST_HDR_SIZE;
      else if (!head_job.hdr_crc_ok)                    status_in = cfsv_pkg::ST_HDR_CRC;
      else if (count_bad)                               status_in = cfsv_pkg::ST_COUNT;
      else if ({12'd0, head_job.total} != exp_len)      status_in = cfsv_pkg::ST_LENGTH;
      else if (!head_job.id_ok)                         status_in = cfsv_pkg::ST_IDENTITY;
      else if (!head_job.payload_crc_ok)                status_in = cfsv_pkg::ST_PAYLOAD_CRC;
      else                                              status_in = cfsv_pkg::ST_OK;

      if (head_job.short_file) begin
         count_in  = '0;
         rate_in   = '0;
         xlow_in   = '0;
         xhigh_in  = '0;
         frames_in = '0;
      end else begin
         count_in  = head_job.band_points;
         rate_in   = head_job.smp_rate;
         xlow_in   = head_job.xover_lo;
         xhigh_in  = head_job.xover_hi;
         frames_in = head_job.frame_total;
      end

      valid_in = pop ? 1'b1 : (rsp.ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         status_ff <= status_in;
         count_ff  <= count_in;
         rate_ff   <= rate_in;
         xlow_ff   <= xlow_in;
         xhigh_ff  <= xhigh_in;
         frames_ff <= frames_in;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.status      = status_ff;
   assign rsp.band_points = count_ff;
   assign rsp.smp_rate    = rate_ff;
   assign rsp.xover_lo    = xlow_ff;
   assign rsp.xover_hi    = xhigh_ff;
   assign rsp.frame_total = frames_ff;

`ifndef SYNTHESIS
   a_short_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (status_ff == cfsv_pkg::ST_SHORT)) |->
         (count_ff == '0) && (frames_ff == '0))
      else $error("short file result carries header fields");
`endif

endmodule

// File: src/cache_file_stream_validator_core.sv
// Cache file stream validator. Takes one file byte per transfer on req_stream, header first,
// and gives one result on rsp_stream for each byte marked last: a status (first failing check)
// and the decoded header fields. A byte is taken every cycle; the only stall comes from the
// two-entry job queue between the byte front end and the status stage, which fills only when
// rsp_stream is back-pressured. A job passes the queue, then the registered status stage.
// The user must write csr_ port registers only while no file is in flight (unenforced).
module cache_file_stream_validator_core #(
   parameter int unsigned MAX_POINTS = cfsv_pkg::MAX_POINTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   cfsv_req_if.sink                          req_stream,
   cfsv_rsp_if.source                        rsp_stream,
   input  logic                              csr_we,
   input  logic [cfsv_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cfsv_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   cfsv_pkg::cfg_type        cfg_ff, cfg_in;
   cfsv_pkg::queue_stat_type q_stat;
   cfsv_pkg::job_type        push_job;
   cfsv_pkg::job_type        head_job;
   logic                     push;
   logic                     pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            cfsv_pkg::CSR_ALGORITHM:    cfg_in.algorithm    = csr_wdata[31:0];
            cfsv_pkg::CSR_SOURCE_SIZE:  cfg_in.source_size  = csr_wdata;
            cfsv_pkg::CSR_SOURCE_MTIME: cfg_in.source_mtime = csr_wdata;
            cfsv_pkg::CSR_PATH_FP:      cfg_in.path_fp      = csr_wdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cfsv_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_stream),
      .cfg    (cfg_ff),
      .q_stat (q_stat),
      .push   (push),
      .job    (push_job)
   );

   cfsv_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .stat     (q_stat)
   );

   cfsv_back #(
      .MAX_POINTS (MAX_POINTS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_stat   (q_stat),
      .head_job (head_job),
      .pop      (pop),
      .rsp      (rsp_stream)
   );

endmodule
